/* rtl/wlsd_pkg.sv */
`default_nettype none

package wlsd_pkg;

  localparam int unsigned RecoverySteps = 5;
  localparam int unsigned RecWidth      = 3;
  localparam int unsigned TickWidth     = 16;
  localparam int unsigned PeriodWidth   = 15;
  localparam int unsigned ShiftWidth    = 4;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned DivSteps      = TickWidth;
  localparam int unsigned DivCntWidth   = $clog2(DivSteps);

  // register indexes of the configuration port
  localparam logic [CfgIdxWidth-1:0] CFG_SLACK     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_PREAMBLE  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_ERR_SHIFT = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_NO_PERIOD = 2'd3;

  localparam logic [TickWidth-1:0]  SLACK_RST     = 16'd83;
  localparam logic [TickWidth-1:0]  PREAMBLE_RST  = 16'd133;
  localparam logic [ShiftWidth-1:0] ERR_SHIFT_RST = 4'd1;
  localparam logic [TickWidth-1:0]  NO_PERIOD_RST = 16'hFFFF;

  // result status codes
  localparam logic [1:0] ST_SUCCESS      = 2'd0;
  localparam logic [1:0] ST_NULL_PERIOD  = 2'd1;
  localparam logic [1:0] ST_NULL_DELAY   = 2'd2;
  localparam logic [1:0] ST_NO_RECEPTION = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_FIN,
    S_EMIT
  } wlsd_state_e;

  typedef struct packed {
    logic load;
    logic eval;
    logic step;
    logic finish;
    logic emit;
  } wlsd_cmd_t;

  typedef struct packed {
    logic early;
    logic need_div;
    logic div_last;
  } wlsd_sts_t;

endpackage

`default_nettype wire

/* rtl/wlsd_ctrl.sv */
`default_nettype none

module wlsd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire wlsd_pkg::wlsd_sts_t sts_i,
  output wlsd_pkg::wlsd_cmd_t     cmd_o
);

  wlsd_pkg::wlsd_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != wlsd_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wlsd_pkg::S_IDLE: begin
        if (in_valid_i) state_d = wlsd_pkg::S_EVAL;
      end
      wlsd_pkg::S_EVAL: begin
        if (sts_i.early)         state_d = wlsd_pkg::S_EMIT;
        else if (sts_i.need_div) state_d = wlsd_pkg::S_DIV;
        else                     state_d = wlsd_pkg::S_FIN;
      end
      wlsd_pkg::S_DIV: begin
        if (sts_i.div_last) state_d = wlsd_pkg::S_FIN;
      end
      wlsd_pkg::S_FIN: begin
        state_d = wlsd_pkg::S_EMIT;
      end
      wlsd_pkg::S_EMIT: begin
        if (out_free) state_d = wlsd_pkg::S_IDLE;
      end
      default: state_d = wlsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == wlsd_pkg::S_IDLE) && in_valid_i;
    cmd_o.eval   = (state_q == wlsd_pkg::S_EVAL);
    cmd_o.step   = (state_q == wlsd_pkg::S_DIV);
    cmd_o.finish = (state_q == wlsd_pkg::S_FIN);
    cmd_o.emit   = (state_q == wlsd_pkg::S_EMIT) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wlsd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/wlsd_dp.sv */
`default_nettype none

module wlsd_dp (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      cfg_we_i,
  input  wire logic [wlsd_pkg::CfgIdxWidth-1:0]          cfg_idx_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]            cfg_data_i,
  input  wire logic                                      action_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]            captured_ticks_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]            rx_period_i,
  input  wire logic [wlsd_pkg::PeriodWidth-1:0]          tx_period_i,
  input  wire logic [wlsd_pkg::PeriodWidth-1:0]          drift_error_i,
  input  wire wlsd_pkg::wlsd_cmd_t                       cmd_i,
  output wlsd_pkg::wlsd_sts_t                            sts_o,
  output logic [1:0]                                     status_o,
  output logic [wlsd_pkg::TickWidth-1:0]                 compare_value_o
);

  localparam int unsigned TW = wlsd_pkg::TickWidth;
  localparam int unsigned PW = wlsd_pkg::PeriodWidth;

  // configuration
  logic [TW-1:0]                    slack_q, preamble_q, no_period_q;
  logic [wlsd_pkg::ShiftWidth-1:0]  err_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q     <= wlsd_pkg::SLACK_RST;
      preamble_q  <= wlsd_pkg::PREAMBLE_RST;
      err_shift_q <= wlsd_pkg::ERR_SHIFT_RST;
      no_period_q <= wlsd_pkg::NO_PERIOD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wlsd_pkg::CFG_SLACK:     slack_q     <= cfg_data_i;
        wlsd_pkg::CFG_PREAMBLE:  preamble_q  <= cfg_data_i;
        wlsd_pkg::CFG_ERR_SHIFT: err_shift_q <= cfg_data_i[wlsd_pkg::ShiftWidth-1:0];
        wlsd_pkg::CFG_NO_PERIOD: no_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched input word
  logic          act_q;
  logic [TW-1:0] cap_q, rx_q;
  logic [PW-1:0] tx_q, drift_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q   <= action_i;
      cap_q   <= captured_ticks_i;
      rx_q    <= rx_period_i;
      tx_q    <= tx_period_i;
      drift_q <= drift_error_i;
    end
  end

  // synchronizer state
  logic [TW-1:0]                 offset_q, offset_d;
  logic                          flag_q, flag_d;
  logic [wlsd_pkg::RecWidth-1:0] rec_q, rec_d;
  logic [TW-1:0]                 terr_q, terr_d;

  // remainder unit and pending result
  logic [PW-1:0]                    rem_q, rem_d;
  logic [TW-1:0]                    dvd_q, dvd_d;
  logic [wlsd_pkg::DivCntWidth-1:0] cnt_q, cnt_d;
  logic                             fold_neg_q, fold_neg_d, fold_pos_q, fold_pos_d;
  logic [1:0]                       res_st_q, res_st_d;
  logic [TW-1:0]                    res_cmp_q, res_cmp_d;

  // listen step, before folding
  logic [PW-1:0]  half;
  logic [TW-1:0]  half_diff;
  logic [TW:0]    twice;
  logic           beats_twice;
  logic [TW-1:0]  offs_pre;
  logic           pre_neg, pre_pos;
  logic [TW-1:0]  dividend;
  logic [TW-1:0]  r_sh;
  logic [TW-1:0]  folded;
  logic [TW-1:0]  cmp;
  logic [TW-1:0]  cmp_diff;

  assign half        = cap_q[TW-1:1];
  assign half_diff   = {1'b0, half} - preamble_q;
  assign twice       = {2'b00, drift_q} << 1;
  assign beats_twice = !offset_q[TW-1] && ({1'b0, offset_q} > twice);

  always_comb begin
    if (flag_q) begin
      if (rx_q < no_period_q) offs_pre = offset_q + {1'b0, tx_q} - rx_q;
      else                    offs_pre = offset_q;
    end else begin
      offs_pre = offset_q - twice[TW-1:0];
    end
  end

  assign pre_neg  = offs_pre[TW-1];
  assign pre_pos  = !offs_pre[TW-1] && (offs_pre > {1'b0, tx_q});
  assign dividend = pre_neg ? (TW'(0) - offs_pre) : (offs_pre - TW'(1));

  assign sts_o.early = act_q || (tx_q == '0) ||
                       (!flag_q && ((rec_q == '0) || !beats_twice));
  assign sts_o.need_div = pre_neg || pre_pos;
  assign sts_o.div_last = (cnt_q == '0);

  assign r_sh = {rem_q, dvd_q[TW-1]};

  always_comb begin
    if (fold_neg_q)      folded = (rem_q == '0) ? '0 : {1'b0, tx_q - rem_q};
    else if (fold_pos_q) folded = {1'b0, rem_q + PW'(1)};
    else                 folded = offset_q;
  end

  // offset*8 plus error, 16-bit wrap
  assign cmp      = {folded[TW-4:0], 3'b000} + terr_q;
  assign cmp_diff = cmp - slack_q;

  always_comb begin
    offset_d   = offset_q;
    flag_d     = flag_q;
    rec_d      = rec_q;
    terr_d     = terr_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    cnt_d      = cnt_q;
    fold_neg_d = fold_neg_q;
    fold_pos_d = fold_pos_q;
    res_st_d   = res_st_q;
    res_cmp_d  = res_cmp_q;

    if (cmd_i.eval) begin
      res_cmp_d = '0;
      if (act_q) begin
        if ({1'b0, half} > preamble_q) terr_d = half_diff >> err_shift_q;
        else                           terr_d = '0;
        flag_d   = 1'b1;
        res_st_d = wlsd_pkg::ST_SUCCESS;
      end else if (tx_q == '0) begin
        res_st_d = wlsd_pkg::ST_NULL_PERIOD;
      end else begin
        if (flag_q) begin
          flag_d = 1'b0;
          rec_d  = wlsd_pkg::RecWidth'(wlsd_pkg::RecoverySteps);
        end else begin
          terr_d = '0;
          rec_d  = rec_q - 1'b1;
        end
        if (!flag_q && rec_q == '0) begin
          offset_d = '0;
          rec_d    = rec_q;
          res_st_d = wlsd_pkg::ST_NO_RECEPTION;
        end else if (!flag_q && !beats_twice) begin
          offset_d = '0;
          rec_d    = '0;
          res_st_d = wlsd_pkg::ST_NULL_DELAY;
        end else begin
          offset_d   = offs_pre;
          fold_neg_d = pre_neg;
          fold_pos_d = pre_pos;
          rem_d      = '0;
          dvd_d      = dividend;
          cnt_d      = wlsd_pkg::DivCntWidth'(wlsd_pkg::DivSteps - 1);
        end
      end
    end

    // one remainder bit a cycle
    if (cmd_i.step) begin
      if (r_sh >= {1'b0, tx_q}) rem_d = PW'(r_sh - {1'b0, tx_q});
      else                      rem_d = r_sh[PW-1:0];
      dvd_d = dvd_q << 1;
      cnt_d = cnt_q - 1'b1;
    end

    if (cmd_i.finish) begin
      if (cmp > slack_q) begin
        offset_d  = {3'b000, cmp_diff[TW-1:3]};
        res_st_d  = wlsd_pkg::ST_SUCCESS;
        res_cmp_d = cmp_diff;
      end else begin
        offset_d  = folded;
        res_st_d  = wlsd_pkg::ST_NULL_DELAY;
        res_cmp_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      flag_q   <= 1'b0;
      rec_q    <= '0;
      terr_q   <= '0;
      cnt_q    <= '0;
    end else begin
      offset_q <= offset_d;
      flag_q   <= flag_d;
      rec_q    <= rec_d;
      terr_q   <= terr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    fold_neg_q <= fold_neg_d;
    fold_pos_q <= fold_pos_d;
    res_st_q   <= res_st_d;
    res_cmp_q  <= res_cmp_d;
    if (cmd_i.emit) begin
      status_o        <= res_st_q;
      compare_value_o <= res_cmp_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/wakeup_listen_sync_delay_core.sv */
`default_nettype none

// Receiver-side wake-up synchronizer. Each input word is either a captured sync
// timing value (action 1) or a listen step (action 0); every word yields exactly
// one result word with a status and a timer compare value. A capture, a listen
// step with a null sender period, and a listen step that ends in recovery
// failure or lost sync pass through the evaluate state and then the emit
// state. A listen step that needs no folding passes through the evaluate,
// finish and emit states. A listen step whose offset must be folded into the
// sender period also passes through the divide state between evaluate and
// finish: the fold runs on a bit-serial remainder unit that produces one bit
// per cycle. One word is in flight at a time; the output register lets the
// next word be accepted while the previous result still waits downstream.
// Configuration must be written only while the block is idle; the block
// itself does not enforce this.
module wakeup_listen_sync_delay_core (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [wlsd_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]       cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic                                 action_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]       captured_ticks_i,
  input  wire logic [wlsd_pkg::TickWidth-1:0]       rx_period_i,
  input  wire logic [wlsd_pkg::PeriodWidth-1:0]     tx_period_i,
  input  wire logic [wlsd_pkg::PeriodWidth-1:0]     drift_error_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [1:0]                                status_o,
  output logic [wlsd_pkg::TickWidth-1:0]            compare_value_o
);

  wlsd_pkg::wlsd_cmd_t cmd;
  wlsd_pkg::wlsd_sts_t sts;

  wlsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wlsd_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (action_i),
    .captured_ticks_i (captured_ticks_i),
    .rx_period_i      (rx_period_i),
    .tx_period_i      (tx_period_i),
    .drift_error_i    (drift_error_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .status_o         (status_o),
    .compare_value_o  (compare_value_o)
  );

endmodule

`default_nettype wire

/* verif/wakeup_listen_sync_delay_core_tb.sv */
`timescale 1ns / 1ps

module wakeup_listen_sync_delay_core_tb;
  import wlsd_pkg::*;

  localparam logic ACT_LISTEN  = 1'b0;
  localparam logic ACT_CAPTURE = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   MAX_PRINTED  = 200;

  typedef struct packed {
    logic [1:0]           status;
    logic [TickWidth-1:0] compare;
  } sync_result_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = CFG_SLACK;
  logic [TickWidth-1:0]   cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic                   action_i = ACT_LISTEN;
  logic [TickWidth-1:0]   captured_ticks_i = '0;
  logic [TickWidth-1:0]   rx_period_i = '0;
  logic [PeriodWidth-1:0] tx_period_i = '0;
  logic [PeriodWidth-1:0] drift_error_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b1;
  logic [1:0]             status_o;
  logic [TickWidth-1:0]   compare_value_o;

  wakeup_listen_sync_delay_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .captured_ticks_i(captured_ticks_i),
    .rx_period_i     (rx_period_i),
    .tx_period_i     (tx_period_i),
    .drift_error_i   (drift_error_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .compare_value_o (compare_value_o)
  );

  // predictor copy of registers and state
  logic [TickWidth-1:0]  cfg_slack;
  logic [TickWidth-1:0]  cfg_preamble;
  logic [ShiftWidth-1:0] cfg_shift;
  logic [TickWidth-1:0]  cfg_no_period;
  logic [TickWidth-1:0]  sync_offset;
  logic                  rx_seen;
  logic [RecWidth-1:0]   recov_left;
  logic [TickWidth-1:0]  timing_err;

  sync_result_t pending_results[$];
  int           err_count = 0;
  bit           no_idle = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("[wakeup_listen_sync_delay_core] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (err_count < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic sync_result_t predict_sync_step(input logic act,
                                                     input logic [TickWidth-1:0] cap,
                                                     input logic [TickWidth-1:0] rx,
                                                     input logic [PeriodWidth-1:0] tx,
                                                     input logic [PeriodWidth-1:0] drift);
    sync_result_t         r;
    int                   half;
    int                   v;
    int                   twice;
    int                   m;
    logic [TickWidth-1:0] cmpv;
    r.status  = ST_SUCCESS;
    r.compare = '0;
    if (act == ACT_CAPTURE) begin
      half = int'(cap) >> 1;
      if (half > int'(cfg_preamble)) timing_err = 16'((half - int'(cfg_preamble)) >> cfg_shift);
      else timing_err = '0;
      rx_seen = 1'b1;
      return r;
    end
    if (tx == '0) begin
      r.status = ST_NULL_PERIOD;
      return r;
    end
    if (rx_seen) begin
      rx_seen    = 1'b0;
      recov_left = RecWidth'(RecoverySteps);
      if (rx < cfg_no_period)
        sync_offset = 16'(int'($signed(sync_offset)) + int'(tx) - int'(rx));
    end else begin
      timing_err = '0;
      if (recov_left != '0) begin
        twice      = int'(drift) * 2;
        recov_left = recov_left - 1'b1;
        v          = int'($signed(sync_offset));
        if (v > twice) begin
          sync_offset = 16'(v - twice);
        end else begin
          sync_offset = '0;
          recov_left  = '0;
          r.status    = ST_NULL_DELAY;
          return r;
        end
      end else begin
        sync_offset = '0;
        r.status    = ST_NO_RECEPTION;
        return r;
      end
    end
    // fold the offset into the sender period
    v = int'($signed(sync_offset));
    if (v < 0) begin
      m = (-v) % int'(tx);
      v = (m == 0) ? 0 : int'(tx) - m;
    end
    if (v > int'(tx)) v = ((v - 1) % int'(tx)) + 1;
    sync_offset = 16'(v);
    cmpv = 16'(v * 8);
    cmpv = cmpv + timing_err;
    if (cmpv > cfg_slack) begin
      cmpv = cmpv - cfg_slack;
    end else begin
      r.status = ST_NULL_DELAY;
      return r;
    end
    sync_offset = cmpv >> 3;
    r.compare   = cmpv;
    return r;
  endfunction

  task automatic send_word(input logic act, input logic [TickWidth-1:0] cap,
                           input logic [TickWidth-1:0] rx, input logic [PeriodWidth-1:0] tx,
                           input logic [PeriodWidth-1:0] drift);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    action_i         <= act;
    captured_ticks_i <= cap;
    rx_period_i      <= rx;
    tx_period_i      <= tx;
    drift_error_i    <= drift;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_results.push_back(predict_sync_step(act, cap, rx, tx, drift));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // block must be idle when this is called
  task automatic set_config(input logic [TickWidth-1:0] slack, input logic [TickWidth-1:0] pre,
                            input logic [ShiftWidth-1:0] shift,
                            input logic [TickWidth-1:0] mark);
    cfg_we_i <= 1'b1; cfg_idx_i <= CFG_SLACK;     cfg_data_i <= slack;
    @(posedge clk_i);
    cfg_idx_i <= CFG_PREAMBLE;  cfg_data_i <= pre;
    @(posedge clk_i);
    cfg_idx_i <= CFG_ERR_SHIFT; cfg_data_i <= TickWidth'(shift);
    @(posedge clk_i);
    cfg_idx_i <= CFG_NO_PERIOD; cfg_data_i <= mark;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    cfg_slack     = slack;
    cfg_preamble  = pre;
    cfg_shift     = shift;
    cfg_no_period = mark;
  endtask

  function automatic logic [TickWidth-1:0] pick_capture();
    case ($urandom_range(0, 3))
      0:       return TickWidth'($urandom);
      1:       return 16'(2 * int'(cfg_preamble) + $urandom_range(0, 2000));
      2:       return TickWidth'($urandom_range(0, 600));
      default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [PeriodWidth-1:0] pick_period();
    case ($urandom_range(0, 3))
      0:       return PeriodWidth'($urandom_range(1, 64));
      1:       return PeriodWidth'($urandom_range(65, 4000));
      2:       return PeriodWidth'($urandom_range(1, 32767));
      default: return 15'h7FFF;
    endcase
  endfunction

  function automatic logic [TickWidth-1:0] pick_rx(input logic [PeriodWidth-1:0] tx);
    int v;
    case ($urandom_range(0, 5))
      0, 1, 2: begin
        v = int'(tx) + $urandom_range(0, 600) - 300;
        if (v < 0) v = 0;
        return TickWidth'(v);
      end
      3:       return TickWidth'($urandom);
      4:       return 16'hFFFF;
      default: return TickWidth'(tx);
    endcase
  endfunction

  function automatic logic [PeriodWidth-1:0] pick_drift();
    if ($urandom_range(0, 3) != 0) return PeriodWidth'($urandom_range(0, 50));
    return PeriodWidth'($urandom);
  endfunction

  // mostly capture / listen / recovery runs, some noise words
  task automatic run_sync_traffic(input int n_words);
    int                   sent;
    int                   steps;
    logic [PeriodWidth-1:0] tx;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(0, 9) < 7) begin
        tx = pick_period();
        send_word(ACT_CAPTURE, pick_capture(), TickWidth'($urandom), PeriodWidth'($urandom),
                  PeriodWidth'($urandom));
        send_word(ACT_LISTEN, TickWidth'($urandom), pick_rx(tx), tx, pick_drift());
        sent += 2;
        steps = $urandom_range(0, 7);
        repeat (steps) begin
          if ($urandom_range(0, 11) == 0) tx = '0;
          else if ($urandom_range(0, 3) == 0) tx = pick_period();
          send_word(ACT_LISTEN, TickWidth'($urandom), pick_rx(tx), tx, pick_drift());
          sent++;
        end
      end else begin
        send_word(1'($urandom), TickWidth'($urandom), TickWidth'($urandom),
                  PeriodWidth'($urandom), PeriodWidth'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    // lost sync and null sender period straight out of reset
    send_word(ACT_LISTEN, 16'h0000, 16'd100, 15'd100, 15'd0);
    send_word(ACT_LISTEN, 16'hFFFF, 16'd100, 15'd0, 15'd0);
    // small capture, then slack not exceeded
    send_word(ACT_CAPTURE, 16'h0000, 16'd0, 15'd0, 15'd0);
    send_word(ACT_LISTEN, 16'h0000, 16'd10, 15'd10, 15'd0);
    // full capture, widest periods
    send_word(ACT_CAPTURE, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    send_word(ACT_LISTEN, 16'h0000, 16'd0, 15'h7FFF, 15'd0);
    // recovery steps: zero drift, then drift too large
    send_word(ACT_LISTEN, 16'h0000, 16'd0, 15'h7FFF, 15'd0);
    send_word(ACT_LISTEN, 16'h0000, 16'd0, 15'h7FFF, 15'h7FFF);
    send_word(ACT_LISTEN, 16'h0000, 16'd0, 15'h7FFF, 15'd0);
    // negative offset folded up
    send_word(ACT_CAPTURE, 16'd1000, 16'd0, 15'd0, 15'd0);
    send_word(ACT_LISTEN, 16'd0, 16'd3000, 15'd1000, 15'd0);
    // receiver period unknown, offset left alone
    send_word(ACT_CAPTURE, 16'd2000, 16'd0, 15'd0, 15'd0);
    send_word(ACT_LISTEN, 16'd0, 16'hFFFF, 15'd500, 15'd0);
    // large offset then small sender period: fold down
    send_word(ACT_CAPTURE, 16'd900, 16'd0, 15'd0, 15'd0);
    send_word(ACT_LISTEN, 16'd0, 16'd0, 15'd5000, 15'd0);
    send_word(ACT_CAPTURE, 16'd900, 16'd0, 15'd0, 15'd0);
    send_word(ACT_LISTEN, 16'd0, 16'd100, 15'd300, 15'd1);
    // full recovery run ending in lost sync
    repeat (6) send_word(ACT_LISTEN, 16'd0, 16'd0, 15'd300, 15'd1);
    send_word(ACT_LISTEN, 16'd0, 16'd0, 15'd1, 15'd0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    set_config(16'd0, 16'd0, 4'd0, 16'd0);
    run_sync_traffic(150);
    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 4'd15, 16'hFFFF);
    run_sync_traffic(150);
    wait_idle();
    set_config(16'd0, 16'd0, 4'd15, 16'hFFFF);
    run_sync_traffic(150);
    wait_idle();
  endtask

  task automatic test_random_settings();
    repeat (6) begin
      set_config(TickWidth'($urandom_range(0, 400)), TickWidth'($urandom_range(0, 1000)),
                 ShiftWidth'($urandom_range(0, 15)),
                 $urandom_range(0, 2) == 0 ? TickWidth'($urandom) : 16'hFFFF);
      run_sync_traffic(175);
      wait_idle();
    end
  endtask

  task automatic test_back_to_back();
    set_config(SLACK_RST, PREAMBLE_RST, ERR_SHIFT_RST, NO_PERIOD_RST);
    no_idle = 1'b1;
    run_sync_traffic(250);
    wait_idle();
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    int           gap;
    sync_result_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status_o, want.status));
        if (compare_value_o !== want.compare)
          report_mismatch($sformatf("compare_value %0d, want %0d", compare_value_o,
                                    want.compare));
      end
    end
  end

  initial begin
    cfg_slack     = SLACK_RST;
    cfg_preamble  = PREAMBLE_RST;
    cfg_shift     = ERR_SHIFT_RST;
    cfg_no_period = NO_PERIOD_RST;
    sync_offset   = '0;
    rx_seen       = 1'b0;
    recov_left    = '0;
    timing_err    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_extremes();
    test_random_settings();
    test_back_to_back();
    if (err_count == 0) $display("[wakeup_listen_sync_delay_core] OK");
    else $display("[wakeup_listen_sync_delay_core] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
rtl/wlsd_pkg.sv
rtl/wlsd_ctrl.sv
rtl/wlsd_dp.sv
rtl/wakeup_listen_sync_delay_core.sv
verif/wakeup_listen_sync_delay_core_tb.sv
